@@ hw/rtl/base64_line_checked_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line-checked Base64 decoder
// Clocked concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_LINE_CHECKED_DECODER_TOP_DEFINES_SVH
`define BASE64_LINE_CHECKED_DECODER_TOP_DEFINES_SVH

// checked only while out of reset
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/b64d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the line-checked Base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] MAX_LINE_RESET = 8'd76;
  localparam int unsigned MID_DEPTH_DEF = 4;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  // character classes produced by the front end
  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_PAD,
    CLS_DASH,
    CLS_BAD
  } cls_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_NOT_MULT4  = 3'd2,
    ST_BAD_CHAR   = 3'd3,
    ST_PAD_MISUSE = 3'd4,
    ST_FINISHED   = 3'd5,
    ST_SKIPPING   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       ends_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    cls_t       cls;
    logic [5:0] sextet;
    logic       ends_line;
  } mid_item_t;

endpackage

@@ hw/rtl/b64d_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo
// Small register queue with push/full and pop/empty, show-ahead read.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hw/rtl/b64d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters and classifies them against the Base64 alphabet.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                 in_push,
  input  b64d_pkg::in_item_t   in_data,
  input  logic                 mid_full,
  output logic                 mid_push,
  output b64d_pkg::mid_item_t  mid_item
);

  logic [7:0] c;

  assign c        = in_data.ch;
  assign mid_push = in_push && !mid_full;

  always_comb begin
    mid_item.ends_line = in_data.ends_line;
    mid_item.sextet    = '0;
    mid_item.cls       = b64d_pkg::CLS_DATA;
    priority if (c >= "A" && c <= "Z") begin
      mid_item.sextet = 6'(c - 8'd65);
    end else if (c >= "a" && c <= "z") begin
      mid_item.sextet = 6'(c - 8'd71);
    end else if (c >= "0" && c <= "9") begin
      mid_item.sextet = 6'(c + 8'd4);
    end else if (c == "+") begin
      mid_item.sextet = 6'd62;
    end else if (c == "/") begin
      mid_item.sextet = 6'd63;
    end else if (c == "=") begin
      mid_item.cls = b64d_pkg::CLS_PAD;
    end else if (c == "-") begin
      mid_item.cls = b64d_pkg::CLS_DASH;
    end else begin
      mid_item.cls = b64d_pkg::CLS_BAD;
    end
  end

endmodule

@@ hw/rtl/b64d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Line and bit state: accumulates sextets, emits bytes, tracks errors.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  b64d_pkg::mid_item_t  mid_item,
  output logic                 mid_pop,
  input  logic                 out_full,
  output logic                 res_push,
  output b64d_pkg::out_item_t  res,
  input  logic [7:0]           max_len
);

  logic [11:0]         acc_r, acc_nxt;
  logic [3:0]          nb_r, nb_nxt;      // bits held from earlier sextets
  logic [7:0]          len_r, len_nxt;
  logic                lpad_r, lpad_nxt;
  logic                apad_r, apad_nxt;
  logic                cmt_r, cmt_nxt;
  logic                fin_r, fin_nxt;
  b64d_pkg::status_t   sticky_r, sticky_nxt;

  logic                fire;
  logic [8:0]          len_inc;
  logic [11:0]         acc_sh;
  logic [3:0]          nb_add;
  logic [3:0]          sh;
  logic [11:0]         shifted;
  b64d_pkg::status_t   st;
  logic                err;

  assign fire     = !mid_empty && !out_full;
  assign mid_pop  = fire;
  assign res_push = fire;

  assign len_inc = {1'b0, len_r} + 9'd1;
  assign acc_sh  = {acc_r[5:0], mid_item.sextet};
  assign nb_add  = nb_r + 4'd6;
  assign sh      = nb_add - 4'd8;
  assign shifted = acc_sh >> sh;

  always_comb begin
    acc_nxt    = acc_r;
    nb_nxt     = nb_r;
    len_nxt    = len_r;
    lpad_nxt   = lpad_r;
    apad_nxt   = apad_r;
    cmt_nxt    = cmt_r;
    fin_nxt    = fin_r;
    sticky_nxt = sticky_r;
    st         = b64d_pkg::ST_OK;
    err        = 1'b0;
    res        = '0;

    priority if (sticky_r != b64d_pkg::ST_OK) begin
      st = sticky_r;
    end else if (fin_r) begin
      st = b64d_pkg::ST_FINISHED;
    end else if (cmt_r || (len_r == '0 && mid_item.cls == b64d_pkg::CLS_DASH)) begin
      cmt_nxt = !mid_item.ends_line;
      st      = b64d_pkg::ST_SKIPPING;
    end else if (len_r == '0 && apad_r) begin
      fin_nxt = 1'b1;
      st      = b64d_pkg::ST_FINISHED;
    end else if (len_inc > {1'b0, max_len} || len_inc > 9'd255) begin
      st  = b64d_pkg::ST_TOO_LONG;
      err = 1'b1;
    end else begin
      len_nxt = len_inc[7:0];
      unique case (mid_item.cls)
        b64d_pkg::CLS_DASH, b64d_pkg::CLS_BAD: begin
          st  = b64d_pkg::ST_BAD_CHAR;
          err = 1'b1;
        end
        b64d_pkg::CLS_PAD: begin
          lpad_nxt = 1'b1;
          apad_nxt = 1'b1;
        end
        b64d_pkg::CLS_DATA: begin
          if (lpad_r) begin
            st  = b64d_pkg::ST_PAD_MISUSE;
            err = 1'b1;
          end else begin
            acc_nxt = acc_sh;
            if (nb_add >= 4'd8) begin
              res.out_byte   = shifted[7:0];
              res.byte_valid = 1'b1;
              nb_nxt         = sh;
            end else begin
              nb_nxt = nb_add;
            end
          end
        end
        default: begin
          st  = b64d_pkg::ST_BAD_CHAR;
          err = 1'b1;
        end
      endcase
      if (!err && mid_item.ends_line && len_inc[1:0] != 2'b00) begin
        st  = b64d_pkg::ST_NOT_MULT4;
        err = 1'b1;
      end
      if (err) begin
        res = '0;
      end else if (mid_item.ends_line) begin
        acc_nxt  = '0;
        nb_nxt   = '0;
        len_nxt  = '0;
        lpad_nxt = 1'b0;
      end
    end
    if (err) begin
      sticky_nxt = st;
    end
    res.status = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      nb_r     <= '0;
      len_r    <= '0;
      lpad_r   <= 1'b0;
      apad_r   <= 1'b0;
      cmt_r    <= 1'b0;
      fin_r    <= 1'b0;
      sticky_r <= b64d_pkg::ST_OK;
    end else if (fire) begin
      acc_r    <= acc_nxt;
      nb_r     <= nb_nxt;
      len_r    <= len_nxt;
      lpad_r   <= lpad_nxt;
      apad_r   <= apad_nxt;
      cmt_r    <= cmt_nxt;
      fin_r    <= fin_nxt;
      sticky_r <= sticky_nxt;
    end
  end

endmodule

@@ hw/rtl/base64_line_checked_decoder_top.sv @@
`timescale 1ns / 1ps
// Characters pass through the mid queue; their results wait in the result queue.
// Throughput: one character per cycle, set by the back end, unless the result queue is full.
// Each character gives exactly one result; a full result queue stalls back end, then input.
// Reset (rst_n low, synchronous): queues emptied, decode state and sticky error cleared,
// max_line_length back to 76. No clearing pass; the block is ready right after reset.
// ----------------------------------------------------------------------------
// base64_line_checked_decoder_top
// Streaming Base64 decoder with comment-line skip and per-line checks.
// ----------------------------------------------------------------------------
module base64_line_checked_decoder_top #(
  parameter int unsigned MID_DEPTH = b64d_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = b64d_pkg::OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // character channel
  input  logic                 in_push,
  output logic                 in_full,
  input  b64d_pkg::in_item_t   in_data,
  // result channel
  output logic                 out_empty,
  input  logic                 out_pop,
  output b64d_pkg::out_item_t  out_data,
  // max_line_length register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  localparam int unsigned MID_W = $bits(b64d_pkg::mid_item_t);
  localparam int unsigned OUT_W = $bits(b64d_pkg::out_item_t);

  logic [7:0]           max_len_r;

  // front end -> queue
  logic                 mid_push;
  logic                 mid_full;
  b64d_pkg::mid_item_t  mid_wr;
  // queue -> back end
  logic                 mid_empty;
  logic                 mid_pop;
  logic [MID_W-1:0]     mid_rdata;
  b64d_pkg::mid_item_t  mid_rd;
  // back end -> result queue
  logic                 res_push;
  logic                 res_full;
  b64d_pkg::out_item_t  res;
  logic [OUT_W-1:0]     out_rdata;

  // Register writes are only legal while idle, so the port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= b64d_pkg::MAX_LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  // Front end: alphabet lookup and classification at the input transfer.
  b64d_front u_front (
    .in_push  (in_push),
    .in_data  (in_data),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_item (mid_wr)
  );

  assign in_full = mid_full;

  // Classified characters wait here so the back end can stall independently.
  b64d_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_rd = b64d_pkg::mid_item_t'(mid_rdata);

  // Back end: line state, bit accumulator, sticky error.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd),
    .mid_pop   (mid_pop),
    .out_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .max_len   (max_len_r)
  );

  // Result queue: the head entry drives the out_ ports.
  b64d_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_data = b64d_pkg::out_item_t'(out_rdata);

endmodule

@@ hw/rtl/b64d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level assertions for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_line_checked_decoder_top_defines.svh"

module b64d_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input b64d_pkg::out_item_t  out_data
);

  logic head_byte;

  assign head_byte = !out_empty && out_data.byte_valid;

  // nothing left over in the result queue after reset
  `B64D_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> out_empty, "result queue not empty after reset")

  // a decoded byte only ever comes with an ok status
  `B64D_ASSERT(a_byte_ok, head_byte |-> (out_data.status == b64d_pkg::ST_OK), "byte not ok")

  // no byte means a zero data field
  `B64D_ASSERT(a_no_byte_zero, (!out_empty && !out_data.byte_valid) |-> (out_data.out_byte == 8'd0), "nonzero byte without valid")

  // a waiting result holds until it is taken
  `B64D_ASSERT(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "stalled result changed")

endmodule

bind base64_line_checked_decoder_top b64d_checker u_b64d_checker (.*);
